// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tat_pkg.sv -----
// Package with the lookup table, widths and stage payload types of the thermistor converter.
`default_nettype none

package tat_pkg;

	localparam int ADC_BITS   = 10;
	localparam int TEMP_BITS  = 10;
	localparam int NUM_POINTS = 16;
	localparam int IDX_BITS   = $clog2(NUM_POINTS);
	localparam int DEN_BITS   = 6;
	localparam int DT_BITS    = 6;
	localparam int NUM_BITS   = DT_BITS + DEN_BITS;
	localparam int Q_BITS     = 6;
	localparam int SH_BITS    = $clog2(Q_BITS);

	typedef logic [ADC_BITS-1:0]         adc_t;
	typedef logic signed [TEMP_BITS-1:0] temp_t;
	typedef logic [IDX_BITS-1:0]         idx_t;
	typedef logic [SH_BITS-1:0]          shift_t;

	localparam adc_t LUT_A [NUM_POINTS] = '{
		10'd950, 10'd928, 10'd900, 10'd867,
		10'd828, 10'd784, 10'd735, 10'd681,
		10'd626, 10'd569, 10'd512, 10'd457,
		10'd404, 10'd355, 10'd310, 10'd270
	};

	localparam temp_t LUT_T [NUM_POINTS] = '{
		-10'sd250, -10'sd200, -10'sd150, -10'sd100,
		-10'sd50,  10'sd0,    10'sd50,   10'sd100,
		10'sd150,  10'sd200,  10'sd250,  10'sd300,
		10'sd350,  10'sd400,  10'sd450,  10'sd500
	};

	localparam temp_t TEMP_MIN = LUT_T[0];
	localparam temp_t TEMP_MAX = LUT_T[NUM_POINTS-1];

	typedef struct packed {
		adc_t reading;
		logic lo;
		logic hi;
		idx_t seg;
	} srch_t;

	typedef struct packed {
		temp_t               base;
		logic [NUM_BITS-1:0] rem;
		logic [DEN_BITS-1:0] den;
		logic [Q_BITS-1:0]   quo;
	} dwork_t;

endpackage

`default_nettype wire

// ----- rtl/tat_search.sv -----
// Segment search stage: compares the reading against every table point.
`default_nettype none

module tat_search import tat_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  adc_t  adc_value,
	output logic  out_valid,
	input  logic  out_ready,
	output srch_t out_data
);

	logic [NUM_POINTS-1:0] gt;
	srch_t                 nxt;
	logic                  vld_s1;
	srch_t                 data_s1;

	always_comb begin
		for (int k = 0; k < NUM_POINTS; k++) begin
			gt[k] = adc_value > LUT_A[k];
		end
		nxt.reading = adc_value;
		nxt.lo      = gt[0];
		nxt.hi      = !gt[NUM_POINTS-1];
		nxt.seg     = '0;
		for (int k = 0; k < NUM_POINTS - 1; k++) begin
			if (!gt[k] && gt[k+1]) begin
				nxt.seg = nxt.seg | IDX_BITS'(k);
			end
		end
	end

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tat_interp.sv -----
// Interpolation setup stage: table lookup of the segment and the numerator product.
`default_nettype none

module tat_interp import tat_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  srch_t  in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output dwork_t out_data
);

	idx_t                seg_nx;
	adc_t                adc_drop;
	adc_t                span;
	temp_t               step;
	logic [DEN_BITS-1:0] drop_n;
	logic [DT_BITS-1:0]  step_n;
	logic [NUM_BITS-1:0] prod;
	dwork_t              nxt;
	logic                vld_s2;
	dwork_t              data_s2;

	always_comb begin
		seg_nx   = in_data.seg + IDX_BITS'(1);
		adc_drop = LUT_A[in_data.seg] - in_data.reading;
		span     = LUT_A[in_data.seg] - LUT_A[seg_nx];
		step     = LUT_T[seg_nx] - LUT_T[in_data.seg];
		drop_n   = adc_drop[DEN_BITS-1:0];
		step_n   = step[DT_BITS-1:0];
		prod     = NUM_BITS'(step_n) * NUM_BITS'(drop_n);

		nxt.quo = '0;
		if (in_data.lo) begin
			nxt.base = TEMP_MIN;
			nxt.rem  = '0;
			nxt.den  = DEN_BITS'(1);
		end else if (in_data.hi) begin
			nxt.base = TEMP_MAX;
			nxt.rem  = '0;
			nxt.den  = DEN_BITS'(1);
		end else begin
			nxt.base = LUT_T[in_data.seg];
			nxt.rem  = prod;
			nxt.den  = span[DEN_BITS-1:0];
		end
	end

	assign in_ready  = !vld_s2 || out_ready;
	assign out_valid = vld_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_ready) begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tat_div.sv -----
// Pipelined restoring divider: three stages of two quotient bits each.
`default_nettype none

module tat_div import tat_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  dwork_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output dwork_t out_data
);

	function automatic dwork_t div_bit(input dwork_t w, input shift_t sh);
		logic [NUM_BITS-1:0] trial;
		dwork_t              r;
		trial = NUM_BITS'(w.den) << sh;
		r     = w;
		if (w.rem >= trial) begin
			r.rem = w.rem - trial;
			r.quo = {w.quo[Q_BITS-2:0], 1'b1};
		end else begin
			r.quo = {w.quo[Q_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic dwork_t div_pair(input dwork_t w, input shift_t sh);
		return div_bit(div_bit(w, sh), sh - shift_t'(1));
	endfunction

	dwork_t nxt_s3;
	dwork_t nxt_s4;
	dwork_t nxt_s5;
	logic   vld_s3;
	logic   vld_s4;
	logic   vld_s5;
	dwork_t data_s3;
	dwork_t data_s4;
	dwork_t data_s5;
	logic   rdy_s3;
	logic   rdy_s4;
	logic   rdy_s5;

	always_comb begin
		nxt_s3 = div_pair(in_data, shift_t'(Q_BITS - 1));
		nxt_s4 = div_pair(data_s3, shift_t'(Q_BITS - 3));
		nxt_s5 = div_pair(data_s4, shift_t'(Q_BITS - 5));
	end

	assign rdy_s5    = !vld_s5 || out_ready;
	assign rdy_s4    = !vld_s4 || rdy_s5;
	assign rdy_s3    = !vld_s3 || rdy_s4;
	assign in_ready  = rdy_s3;
	assign out_valid = vld_s5;
	assign out_data  = data_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				vld_s3 <= in_valid;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s3) begin
			data_s3 <= nxt_s3;
		end
		if (vld_s3 && rdy_s4) begin
			data_s4 <= nxt_s4;
		end
		if (vld_s4 && rdy_s5) begin
			data_s5 <= nxt_s5;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/thermistor_adc_to_temperature.sv -----
// Top level of the thermistor ADC reading to temperature converter.
//
// Each 10-bit reading becomes a temperature in tenths of a degree Celsius, -250 to 500,
// by linear interpolation in a fixed 16-point table; readings outside the table clamp
// to its end points. While the output is not stalled, the block accepts one reading every
// cycle; each result passes through six register stages: one stage searches the table,
// one forms the interpolation product, three stages of a restoring divider take two
// quotient bits each, and the output register adds the offset to the segment base.
// Ready of every stage follows from the stage after it, so empty stages keep taking
// beats while a finished result waits at the output.
`default_nettype none

`include "assert_macros.svh"

module thermistor_adc_to_temperature import tat_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ADC_BITS-1:0]         adc_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [TEMP_BITS-1:0] temperature
);

	logic   srch_valid;
	logic   srch_ready;
	srch_t  srch;
	logic   interp_valid;
	logic   interp_ready;
	dwork_t interp;
	logic   div_valid;
	logic   div_ready;
	dwork_t div_res;
	logic   vld_s6;
	temp_t  temp_s6;

	tat_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.adc_value (adc_value),
		.out_valid (srch_valid),
		.out_ready (srch_ready),
		.out_data  (srch)
	);

	tat_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (srch_valid),
		.in_ready  (srch_ready),
		.in_data   (srch),
		.out_valid (interp_valid),
		.out_ready (interp_ready),
		.out_data  (interp)
	);

	tat_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (interp_valid),
		.in_ready  (interp_ready),
		.in_data   (interp),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_res)
	);

	assign div_ready   = !vld_s6 || out_ready;
	assign out_valid   = vld_s6;
	assign temperature = temp_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (div_ready) begin
			vld_s6 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_valid && div_ready) begin
			temp_s6 <= div_res.base + temp_t'({{(TEMP_BITS-Q_BITS){1'b0}}, div_res.quo});
		end
	end

	`ASSERT_SAME(a_out_range, clk, arst_n, out_valid,
		(temperature >= TEMP_MIN) && (temperature <= TEMP_MAX),
		"temperature beat outside the table range")
	`ASSERT_SAME(a_ready_when_empty, clk, arst_n, !out_valid, in_ready,
		"input stalled while the output stage is empty")
	`ASSERT_SAME(a_clamp_excl, clk, arst_n, srch_valid, !(srch.lo && srch.hi),
		"search stage flags both clamps")
	`ASSERT_SAME(a_quo_range, clk, arst_n, div_valid, div_res.quo < Q_BITS'(50),
		"interpolation offset exceeds one segment")

endmodule

`default_nettype wire
